FILE: rtl/irs_pkg.sv
package irs_pkg;

   // largest span of either range that is still walked
   localparam int MAX_SPAN = 32;
   localparam int SPAN_W   = $clog2(MAX_SPAN + 1);
   // triangle count per run, at most 2*MAX_SPAN-2
   localparam int CNT_W    = $clog2(2 * MAX_SPAN - 1);
   localparam int VAL_W    = 16;
   // integer part of a walk position, signed, room for one step past either end
   localparam int POS_W    = VAL_W + 2;

   typedef enum logic [1:0] {
      OUTCOME_TRIANGLE  = 2'd0,
      OUTCOME_EMPTY     = 2'd1,
      OUTCOME_OVER_SPAN = 2'd2
   } outcome_type;

   typedef enum logic [1:0] {
      WK_IDLE,
      WK_STEP,
      WK_SECOND
   } walk_state_type;

   // one classified transaction, handed from the front to the walker
   typedef struct packed {
      logic                     walk;     // 0: single status result
      outcome_type              outcome;
      logic signed [POS_W-1:0]  qa;       // start position, integer part
      logic        [SPAN_W-1:0] ra;       // start position, fraction in units of 1/len
      logic        [SPAN_W-1:0] step_a;   // |span a|
      logic                     desc_a;
      logic signed [POS_W-1:0]  qb;
      logic        [SPAN_W-1:0] rb;
      logic        [SPAN_W-1:0] step_b;
      logic                     desc_b;
      logic        [SPAN_W-1:0] len;
      logic        [CNT_W-1:0]  total;
   } irs_cmd_type;

endpackage

FILE: rtl/irs_front.sv
module irs_front
   import irs_pkg::*;
(
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [63:0]       req_tdata,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output irs_cmd_type       cmd
);

   logic        [VAL_W-1:0]  a_start, a_end, b_start, b_end;
   logic signed [VAL_W:0]    da, db;
   logic        [VAL_W:0]    na, nb;
   logic        [SPAN_W-1:0] na_s, nb_s, len;
   logic        [SPAN_W:0]   span_sum;
   logic                     over, empty;

   assign a_start = req_tdata[15:0];
   assign a_end   = req_tdata[31:16];
   assign b_start = req_tdata[47:32];
   assign b_end   = req_tdata[63:48];

   // spans and their magnitudes
   assign da = $signed({1'b0, a_end}) - $signed({1'b0, a_start});
   assign db = $signed({1'b0, b_end}) - $signed({1'b0, b_start});
   assign na = da[VAL_W] ? (VAL_W + 1)'(0) - $unsigned(da) : $unsigned(da);
   assign nb = db[VAL_W] ? (VAL_W + 1)'(0) - $unsigned(db) : $unsigned(db);

   // classification: span limit first, then empty strip
   assign over     = (na > (VAL_W + 1)'(MAX_SPAN)) || (nb > (VAL_W + 1)'(MAX_SPAN));
   assign na_s     = na[SPAN_W-1:0];
   assign nb_s     = nb[SPAN_W-1:0];
   assign span_sum = {1'b0, na_s} + {1'b0, nb_s};
   assign empty    = span_sum < (SPAN_W + 1)'(3);
   assign len      = (na_s > nb_s) ? na_s : nb_s;

   // start positions; a descending range begins one step in
   always_comb begin
      cmd         = '0;
      cmd.walk    = !over && !empty;
      cmd.outcome = over ? OUTCOME_OVER_SPAN : (empty ? OUTCOME_EMPTY : OUTCOME_TRIANGLE);
      cmd.len     = len;
      cmd.total   = CNT_W'(span_sum - (SPAN_W + 1)'(2));
      cmd.step_a  = na_s;
      cmd.step_b  = nb_s;
      cmd.desc_a  = da[VAL_W];
      cmd.desc_b  = db[VAL_W];
      if (da[VAL_W]) begin
         cmd.qa = $signed({2'b00, a_start}) - POS_W'(1);
         cmd.ra = len - na_s;
      end else begin
         cmd.qa = $signed({2'b00, a_start});
         cmd.ra = '0;
      end
      if (db[VAL_W]) begin
         cmd.qb = $signed({2'b00, b_start}) - POS_W'(1);
         cmd.rb = len - nb_s;
      end else begin
         cmd.qb = $signed({2'b00, b_start});
         cmd.rb = '0;
      end
   end

   assign cmd_valid  = req_tvalid;
   assign req_tready = cmd_ready;

endmodule

FILE: rtl/irs_queue.sv
module irs_queue
   import irs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   output logic        push_ready,
   input  irs_cmd_type push_cmd,
   output logic        pop_valid,
   input  logic        pop_ready,
   output irs_cmd_type pop_cmd
);

   irs_cmd_type mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  fill_ff, fill_in;
   logic        do_push, do_pop;

   assign push_ready = fill_ff != 2'd2;
   assign pop_valid  = fill_ff != 2'd0;
   assign pop_cmd    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: rtl/irs_walker.sv
module irs_walker
   import irs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  irs_cmd_type       cmd,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [VAL_W-1:0]  corner_0,
   output logic [VAL_W-1:0]  corner_1,
   output logic [VAL_W-1:0]  corner_2,
   output outcome_type       outcome,
   output logic              last
);

   // position = q*len + r with 0 <= r < len; truncation toward zero
   function automatic logic signed [POS_W-1:0] trunc_pos(
      input logic signed [POS_W-1:0] q,
      input logic [SPAN_W-1:0]       r
   );
      logic signed [POS_W-1:0] res;
      res = q;
      if (q < 0 && r != '0) begin
         res = q + POS_W'(1);
      end
      return res;
   endfunction

   walk_state_type          state_ff, state_in;
   irs_cmd_type             cmd_ff, cmd_in;
   logic signed [POS_W-1:0] qa_ff, qa_in, qb_ff, qb_in;
   logic [SPAN_W-1:0]       ra_ff, ra_in, rb_ff, rb_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]        c0_ff, c0_in, c1_ff, c1_in, c2_ff, c2_in;
   outcome_type             outcome_ff, outcome_in;
   logic                    last_ff, last_in;

   logic signed [POS_W-1:0] qa_n, qb_n;
   logic [SPAN_W-1:0]       ra_n, rb_n;
   logic [SPAN_W:0]         sum_a, sum_b;
   logic signed [POS_W-1:0] a0, a1, b0, b1;
   logic                    moved_a, moved_b, out_free, done;
   logic [CNT_W-1:0]        count_inc;

   // one dda step of both ranges
   always_comb begin
      sum_a = cmd_ff.desc_a ? {1'b0, ra_ff} + {1'b0, cmd_ff.len} - {1'b0, cmd_ff.step_a}
                            : {1'b0, ra_ff} + {1'b0, cmd_ff.step_a};
      sum_b = cmd_ff.desc_b ? {1'b0, rb_ff} + {1'b0, cmd_ff.len} - {1'b0, cmd_ff.step_b}
                            : {1'b0, rb_ff} + {1'b0, cmd_ff.step_b};
      qa_n = qa_ff;
      ra_n = sum_a[SPAN_W-1:0];
      if (cmd_ff.desc_a) begin
         if (ra_ff < cmd_ff.step_a) begin
            qa_n = qa_ff - POS_W'(1);
         end else begin
            ra_n = ra_ff - cmd_ff.step_a;
         end
      end else if (sum_a >= {1'b0, cmd_ff.len}) begin
         qa_n = qa_ff + POS_W'(1);
         ra_n = SPAN_W'(sum_a - {1'b0, cmd_ff.len});
      end
      qb_n = qb_ff;
      rb_n = sum_b[SPAN_W-1:0];
      if (cmd_ff.desc_b) begin
         if (rb_ff < cmd_ff.step_b) begin
            qb_n = qb_ff - POS_W'(1);
         end else begin
            rb_n = rb_ff - cmd_ff.step_b;
         end
      end else if (sum_b >= {1'b0, cmd_ff.len}) begin
         qb_n = qb_ff + POS_W'(1);
         rb_n = SPAN_W'(sum_b - {1'b0, cmd_ff.len});
      end
   end

   assign a0        = trunc_pos(qa_ff, ra_ff);
   assign a1        = trunc_pos(qa_n, ra_n);
   assign b0        = trunc_pos(qb_ff, rb_ff);
   assign b1        = trunc_pos(qb_n, rb_n);
   assign moved_a   = a1 != a0;
   assign moved_b   = b1 != b0;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign count_inc = count_ff + CNT_W'(1);
   assign done      = count_inc == cmd_ff.total;
   assign cmd_ready = (state_ff == WK_IDLE) && out_free;

   // walk sequencer and result register
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      qa_in        = qa_ff;
      ra_in        = ra_ff;
      qb_in        = qb_ff;
      rb_in        = rb_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      c0_in        = c0_ff;
      c1_in        = c1_ff;
      c2_in        = c2_ff;
      outcome_in   = outcome_ff;
      last_in      = last_ff;
      unique case (state_ff)
         WK_IDLE: begin
            if (cmd_valid && out_free) begin
               if (cmd.walk) begin
                  cmd_in   = cmd;
                  qa_in    = cmd.qa;
                  ra_in    = cmd.ra;
                  qb_in    = cmd.qb;
                  rb_in    = cmd.rb;
                  count_in = '0;
                  state_in = WK_STEP;
               end else begin
                  rsp_valid_in = 1'b1;
                  c0_in        = '0;
                  c1_in        = '0;
                  c2_in        = '0;
                  outcome_in   = cmd.outcome;
                  last_in      = 1'b1;
               end
            end
         end
         WK_STEP: begin
            if (out_free) begin
               outcome_in = OUTCOME_TRIANGLE;
               last_in    = done;
               c0_in      = a0[VAL_W-1:0];
               c1_in      = b0[VAL_W-1:0];
               c2_in      = moved_a ? a1[VAL_W-1:0] : b1[VAL_W-1:0];
               if (moved_a || moved_b) begin
                  rsp_valid_in = 1'b1;
                  count_in     = count_inc;
               end
               if (moved_a && moved_b && !done) begin
                  state_in = WK_SECOND;
               end else begin
                  qa_in = qa_n;
                  ra_in = ra_n;
                  qb_in = qb_n;
                  rb_in = rb_n;
                  if ((moved_a || moved_b) && done) begin
                     state_in = WK_IDLE;
                  end
               end
            end
         end
         WK_SECOND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               outcome_in   = OUTCOME_TRIANGLE;
               last_in      = done;
               c0_in        = a1[VAL_W-1:0];
               c1_in        = b0[VAL_W-1:0];
               c2_in        = b1[VAL_W-1:0];
               count_in     = count_inc;
               qa_in        = qa_n;
               ra_in        = ra_n;
               qb_in        = qb_n;
               rb_in        = rb_n;
               state_in     = done ? WK_IDLE : WK_STEP;
            end
         end
         default: begin
            state_in = WK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= WK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // walk and result payload
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      qa_ff      <= qa_in;
      ra_ff      <= ra_in;
      qb_ff      <= qb_in;
      rb_ff      <= rb_in;
      count_ff   <= count_in;
      c0_ff      <= c0_in;
      c1_ff      <= c1_in;
      c2_ff      <= c2_in;
      outcome_ff <= outcome_in;
      last_ff    <= last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign corner_0   = c0_ff;
   assign corner_1   = c1_ff;
   assign corner_2   = c2_ff;
   assign outcome    = outcome_ff;
   assign last       = last_ff;

endmodule

FILE: rtl/index_range_stitcher.sv
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  tdata: a start, a end, b start, b end
// rsp      out  rsp_tvalid/rsp_tready  tdata: corners 0..2, tuser: outcome, tlast
//
// a range pair is classified on entry and queued (two entries) for the walker
// the walker emits one triangle per cycle while rsp is not stalled, for a strip of
// total triangles, at most 2*MAX_SPAN-2; a status result is a single beat with tlast set
// reset clears the queue, the walker state and the result valid
// a stalled rsp holds the walker; req is taken while the queue has room
module index_range_stitcher
   import irs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // row_a_start, row_a_end, row_b_start, row_b_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // corner_0, corner_1, corner_2
   output logic [1:0]  rsp_tuser,   // outcome
   output logic        rsp_tlast
);

   logic        front_valid, front_ready;
   irs_cmd_type front_cmd;
   logic        queue_valid, queue_ready;
   irs_cmd_type queue_cmd;
   logic [VAL_W-1:0] corner_0, corner_1, corner_2;
   outcome_type outcome;

   // classify the incoming transaction
   irs_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cmd_valid  (front_valid),
      .cmd_ready  (front_ready),
      .cmd        (front_cmd)
   );

   // decouple front and walker
   irs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_cmd   (front_cmd),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_cmd    (queue_cmd)
   );

   // dda walk and result register
   irs_walker u_walker (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (queue_valid),
      .cmd_ready  (queue_ready),
      .cmd        (queue_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .corner_0   (corner_0),
      .corner_1   (corner_1),
      .corner_2   (corner_2),
      .outcome    (outcome),
      .last       (rsp_tlast)
   );

   assign rsp_tdata = {corner_2, corner_1, corner_0};
   assign rsp_tuser = outcome;

endmodule
